[hw/rtl/rfb_pkg.sv]
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared constants, codes and types of the ring FIFO with bulk transfers.
// ----------------------------------------------------------------------------
`default_nettype none

package rfb_pkg;

  localparam int DEPTH   = 16;
  localparam int WORD_W  = 32;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int FUNC_W  = 2;
  localparam int BURST_W = 4;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 4;
  localparam int SLOT_W  = 5;
  localparam int CMP_W   = (CNT_W > BURST_W) ? CNT_W : BURST_W;
  localparam int LIM_W   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

  localparam int IN_TDATA_W  = ((WORD_W + BURST_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WORD_W + OCC_W + 7) / 8) * 8;

  localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(16);

  localparam logic [FUNC_W-1:0] FUNC_ENQ   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOOFEW  = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occ;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic       pop;
  } oq_stat_t;

endpackage

`default_nettype wire

[hw/rtl/rfb_ram.sv]
// ----------------------------------------------------------------------------
// rfb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rfb_oq.sv]
// ----------------------------------------------------------------------------
// rfb_oq
// Two-entry result queue: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_oq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire rfb_pkg::res_t   push_res,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rfb_pkg::res_t        out_res,
  output rfb_pkg::oq_stat_t    stat
);

  logic          ov;
  logic          sv;
  rfb_pkg::res_t o_res;
  rfb_pkg::res_t s_res;
  logic          pop;

  assign pop       = ov & out_ready;
  assign out_valid = ov;
  assign out_res   = o_res;
  assign stat.cnt  = {1'b0, ov} + {1'b0, sv};
  assign stat.pop  = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (pop) begin
      if (sv) begin
        o_res <= s_res;
        if (push) begin
          s_res <= push_res;
        end else begin
          sv <= 1'b0;
        end
      end else begin
        ov <= push;
        if (push) begin
          o_res <= push_res;
        end
      end
    end else if (push) begin
      if (!ov) begin
        ov    <= 1'b1;
        o_res <= push_res;
      end else begin
        sv    <= 1'b1;
        s_res <= push_res;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rfb_ctrl.sv]
// ----------------------------------------------------------------------------
// rfb_ctrl
// Ring pointers, burst tracking, dequeue sequencer and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rfb_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [rfb_pkg::SLOT_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rfb_pkg::FUNC_W-1:0]    func,
  input  wire logic [rfb_pkg::WORD_W-1:0]    data_word,
  input  wire logic [rfb_pkg::BURST_W-1:0]   burst_count,
  output logic                               mem_we,
  output logic [rfb_pkg::PTR_W-1:0]          mem_waddr,
  output logic [rfb_pkg::WORD_W-1:0]         mem_wdata,
  output logic                               mem_re,
  output logic [rfb_pkg::PTR_W-1:0]          mem_raddr,
  input  wire logic [rfb_pkg::WORD_W-1:0]    mem_rdata,
  input  wire rfb_pkg::oq_stat_t             oq_stat,
  output logic                               push,
  output rfb_pkg::res_t                      push_res
);

  typedef enum logic {IDLE, DEQ} state_t;

  state_t                        state, state_next;
  logic [rfb_pkg::SLOT_W-1:0]    slots;
  logic [rfb_pkg::PTR_W-1:0]     rd_ptr, rd_ptr_next;
  logic [rfb_pkg::PTR_W-1:0]     wr_ptr, wr_ptr_next;
  logic [rfb_pkg::BURST_W-1:0]   burst_left, burst_left_next;
  logic                          burst_refused, burst_refused_next;
  logic [rfb_pkg::BURST_W-1:0]   deq_left, deq_left_next;
  logic [rfb_pkg::OCC_W-1:0]     occ_hold, occ_hold_next;
  logic                          p_valid, p_valid_next;
  logic                          p_rd, p_rd_next;
  rfb_pkg::res_t                 p_res, p_res_next;

  logic [rfb_pkg::LIM_W-1:0]     slots_ext;
  logic [rfb_pkg::CNT_W-1:0]     s_use;
  logic [rfb_pkg::CNT_W-1:0]     held;
  logic [rfb_pkg::CNT_W-1:0]     free_space;
  logic [rfb_pkg::BURST_W-1:0]   n;
  logic                          room;
  logic                          accept;
  logic                          refused_now;
  logic [rfb_pkg::PTR_W-1:0]     rd_inc, wr_inc;
  logic [rfb_pkg::CNT_W-1:0]     held_deq;

  always_comb begin
    slots_ext = rfb_pkg::LIM_W'(slots);
    if (slots_ext < rfb_pkg::LIM_W'(2)) begin
      s_use = rfb_pkg::CNT_W'(2);
    end else if (slots_ext > rfb_pkg::LIM_W'(rfb_pkg::DEPTH)) begin
      s_use = rfb_pkg::CNT_W'(rfb_pkg::DEPTH);
    end else begin
      s_use = rfb_pkg::CNT_W'(slots_ext);
    end
    if (wr_ptr >= rd_ptr) begin
      held = rfb_pkg::CNT_W'(wr_ptr) - rfb_pkg::CNT_W'(rd_ptr);
    end else begin
      held = rfb_pkg::CNT_W'(wr_ptr) + s_use - rfb_pkg::CNT_W'(rd_ptr);
    end
    free_space = s_use - rfb_pkg::CNT_W'(1) - held;
    held_deq   = held - rfb_pkg::CNT_W'(n);
    rd_inc = (rfb_pkg::CNT_W'(rd_ptr) + rfb_pkg::CNT_W'(1) == s_use) ?
             '0 : rd_ptr + rfb_pkg::PTR_W'(1);
    wr_inc = (rfb_pkg::CNT_W'(wr_ptr) + rfb_pkg::CNT_W'(1) == s_use) ?
             '0 : wr_ptr + rfb_pkg::PTR_W'(1);
  end

  assign n = (burst_count == '0) ? rfb_pkg::BURST_W'(1) : burst_count;

  // a new result may enter the stage only if the queue can take it next edge
  assign room = ({1'b0, oq_stat.cnt} + {2'b00, p_valid}) <= (3'd1 + {2'b00, oq_stat.pop});

  assign in_ready = (state == IDLE) && room;
  assign accept   = in_valid && in_ready;

  assign refused_now = (burst_left == '0) ?
                       (rfb_pkg::CMP_W'(free_space) < rfb_pkg::CMP_W'(n)) : burst_refused;

  assign mem_waddr = wr_ptr;
  assign mem_wdata = data_word;
  assign mem_raddr = rd_ptr;

  assign push          = p_valid;
  assign push_res.word = p_rd ? mem_rdata : '0;
  assign push_res.status = p_res.status;
  assign push_res.occ    = p_res.occ;
  assign push_res.last   = p_res.last;

  always_comb begin
    state_next         = state;
    rd_ptr_next        = rd_ptr;
    wr_ptr_next        = wr_ptr;
    burst_left_next    = burst_left;
    burst_refused_next = burst_refused;
    deq_left_next      = deq_left;
    occ_hold_next      = occ_hold;
    p_valid_next       = 1'b0;
    p_rd_next          = 1'b0;
    p_res_next         = p_res;
    p_res_next.word    = '0;
    mem_we             = 1'b0;
    mem_re             = 1'b0;

    if (accept) begin
      p_valid_next = 1'b1;
      unique case (func)
        rfb_pkg::FUNC_ENQ: begin
          burst_refused_next = refused_now;
          burst_left_next    = (burst_left == '0) ? (n - rfb_pkg::BURST_W'(1)) :
                               (burst_left - rfb_pkg::BURST_W'(1));
          p_res_next.last    = 1'b1;
          if (refused_now) begin
            p_res_next.status = rfb_pkg::ST_NOSPACE;
            p_res_next.occ    = rfb_pkg::OCC_W'(held);
          end else begin
            mem_we            = 1'b1;
            wr_ptr_next       = wr_inc;
            p_res_next.status = rfb_pkg::ST_DONE;
            p_res_next.occ    = rfb_pkg::OCC_W'(held + rfb_pkg::CNT_W'(1));
          end
        end
        rfb_pkg::FUNC_DEQ: begin
          if (rfb_pkg::CMP_W'(held) < rfb_pkg::CMP_W'(n)) begin
            p_res_next.status = rfb_pkg::ST_TOOFEW;
            p_res_next.occ    = rfb_pkg::OCC_W'(held);
            p_res_next.last   = 1'b1;
          end else begin
            mem_re            = 1'b1;
            p_rd_next         = 1'b1;
            rd_ptr_next       = rd_inc;
            deq_left_next     = n - rfb_pkg::BURST_W'(1);
            occ_hold_next     = rfb_pkg::OCC_W'(held_deq);
            p_res_next.status = rfb_pkg::ST_DONE;
            p_res_next.occ    = rfb_pkg::OCC_W'(held_deq);
            p_res_next.last   = (n == rfb_pkg::BURST_W'(1));
            if (n != rfb_pkg::BURST_W'(1)) begin
              state_next = DEQ;
            end
          end
        end
        default: begin
          p_res_next.status = rfb_pkg::ST_DONE;
          p_res_next.occ    = rfb_pkg::OCC_W'(held);
          p_res_next.last   = 1'b1;
        end
      endcase
    end else if (state == DEQ && room) begin
      p_valid_next      = 1'b1;
      p_rd_next         = 1'b1;
      mem_re            = 1'b1;
      rd_ptr_next       = rd_inc;
      deq_left_next     = deq_left - rfb_pkg::BURST_W'(1);
      p_res_next.status = rfb_pkg::ST_DONE;
      p_res_next.occ    = occ_hold;
      p_res_next.last   = (deq_left == rfb_pkg::BURST_W'(1));
      if (deq_left == rfb_pkg::BURST_W'(1)) begin
        state_next = IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_res    <= p_res_next;
    occ_hold <= occ_hold_next;
    deq_left <= deq_left_next;
    if (rst) begin
      state         <= IDLE;
      slots         <= rfb_pkg::SLOT_RESET;
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      burst_left    <= '0;
      burst_refused <= 1'b0;
      p_valid       <= 1'b0;
      p_rd          <= 1'b0;
    end else if (cfg_we) begin
      state         <= IDLE;
      slots         <= cfg_wdata;
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      burst_left    <= '0;
      burst_refused <= 1'b0;
      p_valid       <= 1'b0;
      p_rd          <= 1'b0;
    end else begin
      state         <= state_next;
      rd_ptr        <= rd_ptr_next;
      wr_ptr        <= wr_ptr_next;
      burst_left    <= burst_left_next;
      burst_refused <= burst_refused_next;
      p_valid       <= p_valid_next;
      p_rd          <= p_rd_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ring_fifo_bulk_ops.sv]
// ----------------------------------------------------------------------------
// ring_fifo_bulk_ops
// Circular FIFO of data words with all-or-nothing bulk enqueue and dequeue.
// Path: a request's first result is registered in the result stage, then
// enters the result queue. Throughput, while the result queue has room:
// enqueue and count requests one per cycle; a bulk dequeue holds the input
// until its last word, one word per cycle from the single RAM read port.
// Reset: ring empty, ring size 16; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_bulk_ops (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rfb_pkg::SLOT_W-1:0]        cfg_wdata,   // ring_slots
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [rfb_pkg::IN_TDATA_W-1:0]    s_tdata,     // data_word, burst_count
  input  wire logic [rfb_pkg::FUNC_W-1:0]        s_tuser,     // func
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [rfb_pkg::OUT_TDATA_W-1:0]        m_tdata,     // word_out, occupancy
  output logic [rfb_pkg::STAT_W-1:0]             m_tuser,     // status
  output logic                                   m_tlast
);

  logic                          mem_we;
  logic [rfb_pkg::PTR_W-1:0]     mem_waddr;
  logic [rfb_pkg::WORD_W-1:0]    mem_wdata;
  logic                          mem_re;
  logic [rfb_pkg::PTR_W-1:0]     mem_raddr;
  logic [rfb_pkg::WORD_W-1:0]    mem_rdata;
  rfb_pkg::oq_stat_t             oq_stat;
  logic                          push;
  rfb_pkg::res_t                 push_res;
  rfb_pkg::res_t                 out_res;

  rfb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .func        (s_tuser),
    .data_word   (s_tdata[rfb_pkg::WORD_W-1:0]),
    .burst_count (s_tdata[rfb_pkg::WORD_W +: rfb_pkg::BURST_W]),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .oq_stat     (oq_stat),
    .push        (push),
    .push_res    (push_res)
  );

  rfb_ram #(
    .WIDTH (rfb_pkg::WORD_W),
    .DEPTH (rfb_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rfb_oq u_oq (
    .clk       (clk),
    .rst       (rst || cfg_we),
    .push      (push),
    .push_res  (push_res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .stat      (oq_stat)
  );

  assign m_tdata = rfb_pkg::OUT_TDATA_W'({out_res.occ, out_res.word});
  assign m_tuser = out_res.status;
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire

[test/ring_fifo_bulk_ops_test.sv]
// ----------------------------------------------------------------------------
// ring_fifo_bulk_ops_test
// Self-checking bench for the ring FIFO with bulk transfers. A directed table
// covers the empty and full edges, refused and rejected bursts, clamped ring
// sizes, a zero burst count, the spare selector code and wrap-around. Random
// traffic then follows under three idle patterns and one long output stall.
// Every result is checked in order against a bit-true model of the ring.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_fifo_bulk_ops_test;
  import rfb_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_COUNT_ALT = 2'd3;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int LONG_HOLD       = 400;
  localparam int ITEMS_PER_PHASE = 31;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic              is_cfg;
    logic              typed;
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] word;
    logic [BURST_W-1:0] bc;
    res_t              res;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [SLOT_W-1:0]      cfg_wdata = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic [FUNC_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [STAT_W-1:0]      m_tuser;
  logic                   m_tlast;

  // ring model
  logic [WORD_W-1:0]  ring_mem [DEPTH];
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W-1:0]   wr_ptr;
  logic [BURST_W-1:0] burst_left;
  logic               burst_nospace;
  logic [SLOT_W-1:0]  ring_size_reg;

  res_t     ring_results_due [$];
  dir_row_t dir_table [$];

  int mismatches = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_arm = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ring_fifo_bulk_ops i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  function automatic int slots_in_use();
    int s;
    s = ring_size_reg;
    if (s < 2) s = 2;
    if (s > DEPTH) s = DEPTH;
    return s;
  endfunction

  function automatic int words_held();
    return (int'(wr_ptr) + slots_in_use() - int'(rd_ptr)) % slots_in_use();
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return WORD_W'($urandom);
  endfunction

  function automatic dir_row_t row_cfg(input logic [SLOT_W-1:0] v);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.word = WORD_W'(v);
    return r;
  endfunction

  function automatic dir_row_t row_req(input logic [FUNC_W-1:0] func,
                                       input logic [WORD_W-1:0] word,
                                       input logic [BURST_W-1:0] bc);
    dir_row_t r;
    r = '0;
    r.func = func;
    r.word = word;
    r.bc = bc;
    return r;
  endfunction

  function automatic dir_row_t row_chk(input logic [FUNC_W-1:0] func,
                                       input logic [WORD_W-1:0] word,
                                       input logic [BURST_W-1:0] bc,
                                       input logic [WORD_W-1:0] xword,
                                       input logic [STAT_W-1:0] xstatus,
                                       input logic [OCC_W-1:0] xocc);
    dir_row_t r;
    r = row_req(func, word, bc);
    r.typed = 1'b1;
    r.res.word = xword;
    r.res.status = xstatus;
    r.res.occ = xocc;
    r.res.last = 1'b1;
    return r;
  endfunction

  task automatic clear_ring();
    rd_ptr = '0;
    wr_ptr = '0;
    burst_left = '0;
    burst_nospace = 1'b0;
  endtask

  // one accepted request through the ring model; queues its results
  task automatic step_ring(input logic [FUNC_W-1:0] func, input logic [WORD_W-1:0] word,
                           input logic [BURST_W-1:0] bc);
    int s;
    int n;
    int cnt;
    res_t beats [15];
    s = slots_in_use();
    n = (bc == 0) ? 1 : int'(bc);
    cnt = 1;
    beats[0] = '0;
    beats[0].status = ST_DONE;
    beats[0].last = 1'b1;
    case (func)
      FUNC_ENQ: begin
        if (burst_left == 0) begin
          burst_nospace = ((s - 1) - words_held()) < n;
          burst_left = BURST_W'(n - 1);
        end else begin
          burst_left = burst_left - 1'b1;
        end
        if (burst_nospace) begin
          beats[0].status = ST_NOSPACE;
        end else begin
          ring_mem[wr_ptr] = word;
          wr_ptr = PTR_W'((int'(wr_ptr) + 1) % s);
        end
      end
      FUNC_DEQ: begin
        if (words_held() < n) begin
          beats[0].status = ST_TOOFEW;
        end else begin
          cnt = n;
          for (int k = 0; k < n; k++) begin
            beats[k] = '0;
            beats[k].word = ring_mem[rd_ptr];
            beats[k].status = ST_DONE;
            beats[k].last = (k == n - 1);
            rd_ptr = PTR_W'((int'(rd_ptr) + 1) % s);
          end
        end
      end
      default: ;
    endcase
    for (int k = 0; k < cnt; k++) begin
      beats[k].occ = OCC_W'(words_held());
      ring_results_due.push_back(beats[k]);
    end
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [FUNC_W-1:0] func, input logic [WORD_W-1:0] word,
                              input logic [BURST_W-1:0] bc, input logic typed,
                              input res_t texp);
    int depth_before;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_TDATA_W - WORD_W - BURST_W){1'b0}}, bc, word};
    s_tuser <= func;
    do @(posedge clk); while (!s_tready);
    depth_before = ring_results_due.size();
    step_ring(func, word, bc);
    if (typed) begin
      while (ring_results_due.size() > depth_before) void'(ring_results_due.pop_back());
      ring_results_due.push_back(texp);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (ring_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_ring_size(input logic [SLOT_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    ring_size_reg = v;
    clear_ring();
  endtask

  task automatic run_random_traffic(input int target);
    int sent;
    int pick;
    int n;
    int lim;
    sent = 0;
    while (sent < target) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        lim = slots_in_use() - 1 - words_held();
        lim = (lim < 1) ? 1 : ((lim > 15) ? 15 : lim);
        n = ($urandom_range(99) < 70) ? $urandom_range(1, lim) : $urandom_range(15);
        for (int k = 0; k < ((n == 0) ? 1 : n); k++) begin
          if (k > 0 && $urandom_range(99) < 10) begin
            send_request(FUNC_W'($urandom_range(1, 3)), rand_word(),
                         BURST_W'($urandom_range(15)), 1'b0, '0);
            sent++;
          end
          send_request(FUNC_ENQ, rand_word(),
                       (k == 0) ? BURST_W'(n) : BURST_W'($urandom_range(15)), 1'b0, '0);
          sent++;
        end
      end else if (pick < 80) begin
        lim = words_held();
        lim = (lim < 1) ? 1 : ((lim > 15) ? 15 : lim);
        n = ($urandom_range(99) < 70) ? $urandom_range(1, lim) : $urandom_range(15);
        send_request(FUNC_DEQ, rand_word(), BURST_W'(n), 1'b0, '0);
        sent++;
      end else begin
        send_request(FUNC_W'($urandom_range(2, 3)), rand_word(),
                     BURST_W'($urandom_range(15)), 1'b0, '0);
        sent++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm && !hold_done) begin
      m_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    res_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (ring_results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: word %h status %0d occ %0d last %0d",
                   m_tdata[WORD_W-1:0], m_tuser, m_tdata[WORD_W+OCC_W-1:WORD_W], m_tlast);
      end else begin
        due = ring_results_due.pop_front();
        if (m_tdata[WORD_W-1:0] !== due.word || m_tuser !== due.status ||
            m_tdata[WORD_W+OCC_W-1:WORD_W] !== due.occ || m_tlast !== due.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: word/status/occ/last exp %h %0d %0d %0d, got %h %0d %0d %0d",
                     due.word, due.status, due.occ, due.last, m_tdata[WORD_W-1:0], m_tuser,
                     m_tdata[WORD_W+OCC_W-1:WORD_W], m_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ring_fifo_bulk_ops regression: fail");
      $finish;
    end
  end

  initial begin
    logic [SLOT_W-1:0] sizes [6];
    ring_size_reg = SLOT_RESET;
    clear_ring();
    for (int i = 0; i < DEPTH; i++) ring_mem[i] = '0;

    dir_table.push_back(row_chk(FUNC_COUNT, 32'h0, 4'd1, '0, ST_DONE, 4'd0));
    dir_table.push_back(row_chk(FUNC_DEQ, 32'h0, 4'd1, '0, ST_TOOFEW, 4'd0));
    dir_table.push_back(row_chk(FUNC_ENQ, 32'hFFFF_FFFF, 4'd0, '0, ST_DONE, 4'd1));
    dir_table.push_back(row_chk(FUNC_COUNT_ALT, 32'hFFFF_FFFF, 4'd15, '0, ST_DONE, 4'd1));
    dir_table.push_back(row_chk(FUNC_DEQ, 32'h0, 4'd0, 32'hFFFF_FFFF, ST_DONE, 4'd0));
    // burst of three, drained while still open
    dir_table.push_back(row_req(FUNC_ENQ, 32'h0, 4'd3));
    dir_table.push_back(row_req(FUNC_DEQ, 32'h0, 4'd1));
    dir_table.push_back(row_req(FUNC_ENQ, 32'hA5A5_A5A5, 4'd15));
    dir_table.push_back(row_req(FUNC_ENQ, 32'h5A5A_5A5A, 4'd0));
    dir_table.push_back(row_chk(FUNC_DEQ, 32'h0, 4'd15, '0, ST_TOOFEW, 4'd2));
    dir_table.push_back(row_req(FUNC_DEQ, 32'hFFFF_FFFF, 4'd2));
    dir_table.push_back(row_req(FUNC_ENQ, 32'h0000_0001, 4'd1));
    dir_table.push_back(row_chk(FUNC_ENQ, 32'hFFFF_0000, 4'd15, '0, ST_NOSPACE, 4'd1));
    // size write with the rejected burst still open; clamps up to 2
    dir_table.push_back(row_cfg(5'd0));
    dir_table.push_back(row_chk(FUNC_ENQ, 32'h1234_5678, 4'd1, '0, ST_DONE, 4'd1));
    dir_table.push_back(row_chk(FUNC_ENQ, 32'h8765_4321, 4'd1, '0, ST_NOSPACE, 4'd1));
    dir_table.push_back(row_chk(FUNC_DEQ, 32'h0, 4'd1, 32'h1234_5678, ST_DONE, 4'd0));
    dir_table.push_back(row_cfg(5'd3));
    dir_table.push_back(row_req(FUNC_ENQ, 32'hAAAA_AAAA, 4'd2));
    dir_table.push_back(row_req(FUNC_ENQ, 32'h5555_5555, 4'd0));
    dir_table.push_back(row_req(FUNC_DEQ, 32'h0, 4'd1));
    dir_table.push_back(row_req(FUNC_ENQ, 32'hC3C3_C3C3, 4'd1));
    dir_table.push_back(row_req(FUNC_DEQ, 32'h0, 4'd2));
    // clamps down to 16
    dir_table.push_back(row_cfg(5'd31));
    dir_table.push_back(row_chk(FUNC_COUNT, 32'h0, 4'd1, '0, ST_DONE, 4'd0));

    sizes[0] = 5'd16;
    sizes[1] = 5'd2;
    sizes[2] = SLOT_W'($urandom_range(17, 31));
    sizes[3] = SLOT_W'($urandom_range(3, 15));
    sizes[4] = 5'd1;
    sizes[5] = SLOT_W'($urandom_range(31));

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 63;
    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg)
        write_ring_size(dir_table[i].word[SLOT_W-1:0]);
      else
        send_request(dir_table[i].func, dir_table[i].word, dir_table[i].bc,
                     dir_table[i].typed, dir_table[i].res);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : ((phase == 1) ? 63 : 0);
      recv_idle_pct = (phase == 0) ? 63 : ((phase == 1) ? 11 : 0);
      for (int sub = 0; sub < 2; sub++) begin
        write_ring_size(sizes[phase * 2 + sub]);
        if (phase == 2 && sub == 0) hold_arm = 1'b1;
        run_random_traffic(ITEMS_PER_PHASE);
      end
    end

    drain();
    if (mismatches == 0 && ring_results_due.size() == 0)
      $display("ring_fifo_bulk_ops regression: pass");
    else
      $display("ring_fifo_bulk_ops regression: fail");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/rfb_pkg.sv
hw/rtl/rfb_ram.sv
hw/rtl/rfb_oq.sv
hw/rtl/rfb_ctrl.sv
hw/rtl/ring_fifo_bulk_ops.sv
test/ring_fifo_bulk_ops_test.sv
